// ===== hdl/pdh_pkg.sv =====
// Package for the pair distance histogram unit.
// Holds the sizing constants and the record and result beat structs.
// No dependencies.
`default_nettype none

package pdh_pkg;

	localparam int NUM_BINS   = 1024;
	localparam int BIN_BITS   = $clog2(NUM_BINS);
	localparam int POS_BITS   = 28;
	localparam int BSIZE_BITS = 21;
	localparam int CHROM_BITS = 8;
	localparam int CNT_BITS   = 32;

	typedef struct packed {
		logic [CHROM_BITS-1:0] first_chromosome;
		logic [CHROM_BITS-1:0] second_chromosome;
		logic [POS_BITS-1:0]   first_site;
		logic [POS_BITS-1:0]   second_site;
	} rec_t;

	typedef struct packed {
		logic                is_inter;
		logic [BIN_BITS-1:0] bin_index;
		logic [CNT_BITS-1:0] bin_count;
		logic [CNT_BITS-1:0] inter_total;
		logic [CNT_BITS-1:0] intra_total;
	} res_t;

	// saturating increment of a 32-bit counter
	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
		logic [CNT_BITS-1:0] r;
		r = (&v) ? v : v + {{(CNT_BITS-1){1'b0}}, 1'b1};
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pdh_divider.sv =====
// Serial restoring divider: one quotient bit per cycle.
// Depends on pdh_pkg for the position and bin size widths.
`default_nettype none

module pdh_divider (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [pdh_pkg::POS_BITS-1:0]     dividend,
	input  wire logic [pdh_pkg::BSIZE_BITS-1:0]   divisor,
	output logic                                  done,
	output logic [pdh_pkg::POS_BITS-1:0]          quotient
);

	localparam int STEP_W = $clog2(pdh_pkg::POS_BITS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pdh_pkg::POS_BITS - 1);

	logic                              busy_q;
	logic [STEP_W-1:0]                 step_q;
	logic [pdh_pkg::BSIZE_BITS-1:0]    rem_q;
	logic [pdh_pkg::BSIZE_BITS-1:0]    dvs_q;
	logic [pdh_pkg::POS_BITS-1:0]      quo_q;
	logic [pdh_pkg::BSIZE_BITS:0]      trial;
	logic                              fits;
	logic [pdh_pkg::BSIZE_BITS:0]      diff;

	// a zero divisor always fits, so the quotient comes out all ones
	assign trial = {rem_q, quo_q[pdh_pkg::POS_BITS-1]};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[pdh_pkg::BSIZE_BITS-1:0] : trial[pdh_pkg::BSIZE_BITS-1:0];
			quo_q <= {quo_q[pdh_pkg::POS_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hdl/pdh_hist_ram.sv =====
// Histogram count store: one write port, one registered read port.
// Depends on pdh_pkg for depth and count width.
`default_nettype none

module pdh_hist_ram (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [pdh_pkg::BIN_BITS-1:0]  waddr,
	input  wire logic [pdh_pkg::CNT_BITS-1:0]  wdata,
	input  wire logic                          re,
	input  wire logic [pdh_pkg::BIN_BITS-1:0]  raddr,
	output logic      [pdh_pkg::CNT_BITS-1:0]  rdata
);

	logic [pdh_pkg::CNT_BITS-1:0] mem [pdh_pkg::NUM_BINS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/pair_distance_histogram_unit.sv =====
// Pair distance histogram unit. Intra record, from accept to result: 28 divider
// steps, bin latch, bin read, update, output load; inter record: output load.
// One record at a time: rec_stall stays high until the result is loaded, so a new
// record is taken only after the previous result is loaded, later under res_stall.
// After arst_n releases, a clearing pass writes zero to all 1024 bins with rec_stall
// high; configuration writes are taken throughout.
`default_nettype none

module pair_distance_histogram_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             rec_valid,
	output logic                                  rec_stall,
	input  wire pdh_pkg::rec_t                    rec,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output pdh_pkg::res_t                         res,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pdh_pkg::BSIZE_BITS-1:0]   cfg_data
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [pdh_pkg::BIN_BITS-1:0] LAST_BIN = pdh_pkg::BIN_BITS'(pdh_pkg::NUM_BINS - 1);

	logic [2:0]                        state_q;
	logic [pdh_pkg::BIN_BITS-1:0]      clr_q;
	logic [pdh_pkg::BSIZE_BITS-1:0]    bin_size_q;
	logic [pdh_pkg::CNT_BITS-1:0]      inter_q;
	logic [pdh_pkg::CNT_BITS-1:0]      intra_q;
	logic [pdh_pkg::BIN_BITS-1:0]      bin_q;
	logic                              pend_inter_q;
	logic [pdh_pkg::CNT_BITS-1:0]      pend_cnt_q;
	logic                              res_valid_q;
	pdh_pkg::res_t                     res_q;

	logic                              rec_fire;
	logic                              same_chrom;
	logic [pdh_pkg::POS_BITS-1:0]      site_gap;
	logic                              div_start;
	logic                              div_done;
	logic [pdh_pkg::POS_BITS-1:0]      quotient;
	logic                              out_free;
	logic                              ram_we;
	logic [pdh_pkg::BIN_BITS-1:0]      ram_waddr;
	logic [pdh_pkg::CNT_BITS-1:0]      ram_wdata;
	logic [pdh_pkg::CNT_BITS-1:0]      ram_rdata;
	logic [pdh_pkg::CNT_BITS-1:0]      new_cnt;

	assign rec_stall  = (state_q != ST_IDLE);
	assign rec_fire   = rec_valid && !rec_stall;
	assign same_chrom = (rec.first_chromosome == rec.second_chromosome);
	assign site_gap   = (rec.first_site >= rec.second_site) ? rec.first_site - rec.second_site
	                                                        : rec.second_site - rec.first_site;
	assign div_start  = rec_fire && same_chrom;
	assign out_free   = !res_valid_q || !res_stall;
	assign new_cnt    = pdh_pkg::sat_inc(ram_rdata);

	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// clearing pass owns the write port until it finishes
	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_UPD);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : bin_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : new_cnt;

	pdh_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (site_gap),
		.divisor  (bin_size_q),
		.done     (div_done),
		.quotient (quotient)
	);

	pdh_hist_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (state_q == ST_RD),
		.raddr (bin_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q <= pdh_pkg::BSIZE_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			bin_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			inter_q     <= '0;
			intra_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + pdh_pkg::BIN_BITS'(1);
					if (clr_q == LAST_BIN)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (rec_fire) begin
						if (same_chrom) begin
							state_q <= ST_DIV;
						end else begin
							inter_q <= pdh_pkg::sat_inc(inter_q);
							state_q <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					intra_q <= pdh_pkg::sat_inc(intra_q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		if (rec_fire)
			pend_inter_q <= !same_chrom;
		if (state_q == ST_DIV && div_done) begin
			// far distances fold into the last bin
			bin_q <= (quotient >= pdh_pkg::POS_BITS'(pdh_pkg::NUM_BINS - 1))
			         ? LAST_BIN : quotient[pdh_pkg::BIN_BITS-1:0];
		end
		if (state_q == ST_UPD)
			pend_cnt_q <= new_cnt;
		if (state_q == ST_OUT && out_free) begin
			res_q.is_inter    <= pend_inter_q;
			res_q.bin_index   <= pend_inter_q ? '0 : bin_q;
			res_q.bin_count   <= pend_inter_q ? '0 : pend_cnt_q;
			res_q.inter_total <= inter_q;
			res_q.intra_total <= intra_q;
		end
	end

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !res_valid_q)
		else $error("result beat during clearing pass");

	a_inter_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.is_inter) |-> (res_q.bin_index == '0 && res_q.bin_count == '0))
		else $error("inter result carries bin fields");

	a_intra_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (intra_q >= $past(intra_q)))
		else $error("intra counter went down");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> (res_valid_q && $stable(res_q)))
		else $error("stalled result beat changed");

endmodule

`default_nettype wire

// ===== tb/sv/tb_pair_distance_histogram_unit.sv =====
// Self-checking testbench for pair_distance_histogram_unit: directed table, then random records.
// Every result beat is checked field by field, in order, against a local histogram predictor or a typed row.
// Depends on pdh_pkg (record/result structs, sizing constants).

module tb_pair_distance_histogram_unit;

	localparam logic [pdh_pkg::POS_BITS-1:0]   SITE_MAX    = {pdh_pkg::POS_BITS{1'b1}};
	localparam logic [pdh_pkg::BSIZE_BITS-1:0] BSIZE_MAX   = {pdh_pkg::BSIZE_BITS{1'b1}};
	localparam logic [pdh_pkg::BSIZE_BITS-1:0] BSIZE_TOP   = 21'd1048576;
	localparam logic [pdh_pkg::BIN_BITS-1:0]   LAST_BIN    =
		pdh_pkg::BIN_BITS'(pdh_pkg::NUM_BINS - 1);
	localparam int                             CYCLE_LIMIT = 1000000;
	localparam int                             TAIL_CYCLES = 40;
	localparam int                             PHASE_ITEMS = 300;
	localparam int                             NUM_PHASES  = 6;

	typedef struct packed {
		logic [pdh_pkg::BSIZE_BITS-1:0] bin_size;
		pdh_pkg::rec_t                  rec;
		logic                           typed;
		pdh_pkg::res_t                  want;
	} dir_row_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           rec_valid = 1'b0;
	pdh_pkg::rec_t                  rec       = '0;
	logic                           res_stall = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic [pdh_pkg::BSIZE_BITS-1:0] cfg_data  = '0;
	logic                           rec_stall;
	logic                           res_valid;
	pdh_pkg::res_t                  res;
	logic                           cfg_ready;

	// predictor state
	logic [pdh_pkg::CNT_BITS-1:0]   hist_bins [pdh_pkg::NUM_BINS];
	logic [pdh_pkg::CNT_BITS-1:0]   inter_seen;
	logic [pdh_pkg::CNT_BITS-1:0]   intra_seen;
	logic [pdh_pkg::BSIZE_BITS-1:0] cur_bin_size;

	pdh_pkg::res_t pending_results [$];
	dir_row_t      dir_rows [$];
	int            mismatch_count = 0;
	int            result_count   = 0;
	int            cycle_count    = 0;
	int            stall_left     = 0;
	logic          stall_now      = 1'b0;

	pair_distance_histogram_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec      (rec),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [pdh_pkg::CNT_BITS-1:0] bump(
			input logic [pdh_pkg::CNT_BITS-1:0] v);
		return (v == {pdh_pkg::CNT_BITS{1'b1}}) ? v : v + pdh_pkg::CNT_BITS'(1);
	endfunction

	// updates the local histogram with one record, returns the result beat it causes
	function automatic pdh_pkg::res_t histogram_update(input pdh_pkg::rec_t r);
		pdh_pkg::res_t                o;
		longint unsigned              s1, s2, site_gap, quot;
		logic [pdh_pkg::BIN_BITS-1:0] bin;
		o = '0;
		if (r.first_chromosome != r.second_chromosome) begin
			inter_seen = bump(inter_seen);
			o.is_inter = 1'b1;
		end else begin
			s1       = 64'(r.first_site);
			s2       = 64'(r.second_site);
			site_gap = (s1 >= s2) ? s1 - s2 : s2 - s1;
			if (cur_bin_size == '0) begin
				bin = LAST_BIN;   // divide by zero gives all-ones quotient
			end else begin
				quot = site_gap / 64'(cur_bin_size);
				bin  = (quot >= 64'(pdh_pkg::NUM_BINS - 1)) ? LAST_BIN
				                                            : pdh_pkg::BIN_BITS'(quot);
			end
			hist_bins[bin] = bump(hist_bins[bin]);
			intra_seen     = bump(intra_seen);
			o.bin_index    = bin;
			o.bin_count    = hist_bins[bin];
		end
		o.inter_total = inter_seen;
		o.intra_total = intra_seen;
		return o;
	endfunction

	function automatic void add_row(input int unsigned bs,
			input int unsigned c1, input int unsigned c2,
			input int unsigned s1, input int unsigned s2,
			input int unsigned typed, input int unsigned isx, input int unsigned bi,
			input int unsigned bc, input int unsigned it, input int unsigned nt);
		dir_row_t d;
		d.bin_size                  = pdh_pkg::BSIZE_BITS'(bs);
		d.rec.first_chromosome      = pdh_pkg::CHROM_BITS'(c1);
		d.rec.second_chromosome     = pdh_pkg::CHROM_BITS'(c2);
		d.rec.first_site            = pdh_pkg::POS_BITS'(s1);
		d.rec.second_site           = pdh_pkg::POS_BITS'(s2);
		d.typed                     = (typed != 0);
		d.want.is_inter             = (isx != 0);
		d.want.bin_index            = pdh_pkg::BIN_BITS'(bi);
		d.want.bin_count            = pdh_pkg::CNT_BITS'(bc);
		d.want.inter_total          = pdh_pkg::CNT_BITS'(it);
		d.want.intra_total          = pdh_pkg::CNT_BITS'(nt);
		dir_rows.push_back(d);
	endfunction

	task automatic note_mismatch(input string field, input logic [pdh_pkg::CNT_BITS-1:0] got,
			input logic [pdh_pkg::CNT_BITS-1:0] want);
		$display("mismatch at result %0d, %s: got %0h, want %0h", result_count, field, got, want);
		mismatch_count++;
	endtask

	// drives one record beat and holds it until taken; prediction at the accepting edge
	task automatic send_record(input pdh_pkg::rec_t r, input logic typed,
			input pdh_pkg::res_t want);
		pdh_pkg::res_t p;
		rec_valid <= 1'b1;
		rec       <= r;
		do @(posedge clk); while (rec_stall);
		p = histogram_update(r);
		pending_results.push_back(typed ? want : p);
	endtask

	task automatic sender_gap(input bit bursty);
		int gap;
		int pick;
		gap  = 0;
		pick = $urandom_range(0, 99);
		if (!bursty) begin
			if (pick >= 90)
				gap = $urandom_range(6, 40);
			else if (pick >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender stops until every pending result beat is back
	task automatic drain;
		rec_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_bin_size(input logic [pdh_pkg::BSIZE_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		cur_bin_size  = v;
	endtask

	// result side: checker, stall generator, cycle limit
	always @(posedge clk) begin
		pdh_pkg::res_t want;
		cycle_count++;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("beat with no pending record", res.intra_total, '0);
			end else begin
				want = pending_results.pop_front();
				if (res.is_inter !== want.is_inter)
					note_mismatch("is_inter", pdh_pkg::CNT_BITS'(res.is_inter),
						pdh_pkg::CNT_BITS'(want.is_inter));
				if (res.bin_index !== want.bin_index)
					note_mismatch("bin_index", pdh_pkg::CNT_BITS'(res.bin_index),
						pdh_pkg::CNT_BITS'(want.bin_index));
				if (res.bin_count !== want.bin_count)
					note_mismatch("bin_count", res.bin_count, want.bin_count);
				if (res.inter_total !== want.inter_total)
					note_mismatch("inter_total", res.inter_total, want.inter_total);
				if (res.intra_total !== want.intra_total)
					note_mismatch("intra_total", res.intra_total, want.intra_total);
			end
			result_count++;
		end
		if (stall_left == 0) begin
			if ($urandom_range(0, 99) < 35) begin
				stall_now  = 1'b1;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
				                                         : $urandom_range(1, 3);
			end else begin
				stall_now  = 1'b0;
				stall_left = $urandom_range(1, 20);
			end
		end else begin
			stall_left--;
		end
		res_stall <= stall_now;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		pdh_pkg::rec_t                  r;
		pdh_pkg::res_t                  none;
		logic [pdh_pkg::BSIZE_BITS-1:0] phase_bs [NUM_PHASES];
		longint unsigned                span, base, site_gap;
		bit                             bursty;
		int                             pick;

		none = '0;
		for (int i = 0; i < pdh_pkg::NUM_BINS; i++) hist_bins[i] = '0;
		inter_seen   = '0;
		intra_seen   = '0;
		cur_bin_size = pdh_pkg::BSIZE_BITS'(1);

		// bin size, chromosomes, sites, typed?, expected beat
		add_row(1, 0, 0, 0, 0,                 1, 0, 0, 1, 0, 1);
		add_row(1, 255, 255, SITE_MAX, 0,      1, 0, 1023, 1, 0, 2);
		add_row(1, 0, 255, 0, SITE_MAX,        1, 1, 0, 0, 1, 2);
		add_row(1, 255, 0, SITE_MAX, SITE_MAX, 1, 1, 0, 0, 2, 2);
		add_row(1, 7, 7, 0, SITE_MAX,          1, 0, 1023, 2, 2, 3);
		add_row(1, 9, 9, 1022, 0,              1, 0, 1022, 1, 2, 4);
		add_row(1, 9, 9, 1023, 0,              1, 0, 1023, 3, 2, 5);
		add_row(1, 12, 12, 100, 105,           1, 0, 5, 1, 2, 6);
		add_row(1, 12, 12, 105, 100,           1, 0, 5, 2, 2, 7);
		add_row(1, 8'hAA, 8'h55, 28'h5555555, 28'hAAAAAAA, 1, 1, 0, 0, 3, 7);
		add_row(1, 8'h55, 8'h55, 28'hAAAAAAA, 28'h5555555, 1, 0, 1023, 4, 3, 8);
		add_row(BSIZE_TOP, 3, 3, SITE_MAX, 0,  0, 0, 0, 0, 0, 0);
		add_row(BSIZE_TOP, 3, 3, 1048575, 0,   0, 0, 0, 0, 0, 0);
		add_row(BSIZE_TOP, 3, 3, 0, 1048576,   0, 0, 0, 0, 0, 0);
		// zero bin size folds into the last bin
		add_row(0, 1, 1, 5, 5,                 0, 0, 0, 0, 0, 0);
		add_row(0, 1, 2, 5, 5,                 0, 0, 0, 0, 0, 0);
		add_row(BSIZE_MAX, 200, 200, SITE_MAX, 0, 0, 0, 0, 0, 0, 0);
		add_row(BSIZE_MAX, 200, 200, 0, 2097150,  0, 0, 0, 0, 0, 0);
		add_row(262145, 4, 4, SITE_MAX, 0,     0, 0, 0, 0, 0, 0);
		add_row(3, 4, 4, 3068, 0,              0, 0, 0, 0, 0, 0);
		add_row(3, 4, 4, 0, 3069,              0, 0, 0, 0, 0, 0);
		add_row(3, 4, 4, 3069, 3069,           0, 0, 0, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].bin_size != cur_bin_size) begin
				drain;
				write_bin_size(dir_rows[i].bin_size);
			end
			send_record(dir_rows[i].rec, dir_rows[i].typed, dir_rows[i].want);
			sender_gap(1'b0);
		end

		phase_bs[0] = pdh_pkg::BSIZE_BITS'(1);
		phase_bs[1] = '0;
		phase_bs[2] = BSIZE_TOP;
		phase_bs[3] = BSIZE_MAX;
		phase_bs[4] = pdh_pkg::BSIZE_BITS'($urandom_range(2, 64));
		phase_bs[5] = pdh_pkg::BSIZE_BITS'($urandom_range(1, 2097151));

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain;
			write_bin_size(phase_bs[p]);
			bursty = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					bursty = ($urandom_range(0, 3) == 0);
				if (n == PHASE_ITEMS / 2)
					drain;
				r.first_chromosome  = pdh_pkg::CHROM_BITS'($urandom_range(0, 255));
				r.second_chromosome = ($urandom_range(0, 99) < 20)
				                      ? pdh_pkg::CHROM_BITS'($urandom_range(0, 255))
				                      : r.first_chromosome;
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					// distance spread over the bins at the current size
					span = (cur_bin_size == '0) ? 64'd2000
					                            : 64'(cur_bin_size) * 64'd1100;
					if (span > 64'(SITE_MAX)) span = 64'(SITE_MAX);
					site_gap = {$urandom, $urandom} % (span + 64'd1);
					base     = {$urandom, $urandom} % (64'(SITE_MAX) - site_gap + 64'd1);
					if ($urandom_range(0, 1)) begin
						r.first_site  = pdh_pkg::POS_BITS'(base + site_gap);
						r.second_site = pdh_pkg::POS_BITS'(base);
					end else begin
						r.first_site  = pdh_pkg::POS_BITS'(base);
						r.second_site = pdh_pkg::POS_BITS'(base + site_gap);
					end
				end else if (pick < 75) begin
					r.first_site  = pdh_pkg::POS_BITS'($urandom);
					r.second_site = pdh_pkg::POS_BITS'($urandom);
				end else begin
					r.first_site  = $urandom_range(0, 1)
					                ? SITE_MAX - pdh_pkg::POS_BITS'($urandom_range(0, 15))
					                : pdh_pkg::POS_BITS'($urandom_range(0, 15));
					r.second_site = $urandom_range(0, 1)
					                ? SITE_MAX - pdh_pkg::POS_BITS'($urandom_range(0, 15))
					                : pdh_pkg::POS_BITS'($urandom_range(0, 15));
				end
				send_record(r, 1'b0, none);
				sender_gap(bursty);
			end
		end

		drain;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
